@@ hdl/rlb_pkg.sv @@
package rlb_pkg;

    localparam int unsigned LANES = 3;

    localparam logic [1:0] MODE_MULTIPLY = 2'd0;
    localparam logic [1:0] MODE_SUBTRACT = 2'd1;
    localparam logic [1:0] MODE_SCREEN   = 2'd2;
    localparam logic [1:0] MODE_OVERLAY  = 2'd3;

    typedef struct packed {
        logic [7:0] base_red;
        logic [7:0] base_green;
        logic [7:0] base_blue;
        logic [7:0] over_red;
        logic [7:0] over_green;
        logic [7:0] over_blue;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } pix_out_t;

    typedef struct packed {
        logic       inv;
        logic       bypass;
        logic [7:0] byp_val;
    } lane_ctl_t;

    typedef struct packed {
        logic [7:0] opa;
        logic [7:0] opb;
        logic       dbl;
        lane_ctl_t  ctl;
    } lane_op_t;

    typedef struct packed {
        logic [16:0] prod;
        lane_ctl_t   ctl;
    } lane_prod_t;

    typedef struct packed {
        logic [17:0] num;
        logic [8:0]  est;
        lane_ctl_t   ctl;
    } lane_est_t;

endpackage

@@ hdl/rgb_layer_blend_unit_top.sv @@
// channel  valid      stall      payload
// request  req_valid  req_stall  req_data  (base and layer pixel)
// result   rsp_valid  rsp_stall  rsp_data  (blended pixel)
// config   cfg_wr_en  -          cfg_wr_data (blend mode)
//
// one pixel per cycle unless the result side stalls; each stage below registers the pixel on its way to rsp_data
// stages: operand select, 8x8 multiply, reciprocal estimate, correct and finish
// each stage holds its own request, so bubbles close up under a stall
// reset clears the stage valid bits and sets the mode to multiply
module rgb_layer_blend_unit_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_wr_data,
    input  logic             req_valid,
    output logic             req_stall,
    input  rlb_pkg::pix_in_t req_data,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rlb_pkg::pix_out_t rsp_data
);

    logic [1:0]                               mode_reg;
    logic [rlb_pkg::LANES-1:0][7:0]           lane_a;
    logic [rlb_pkg::LANES-1:0][7:0]           lane_b;
    logic [rlb_pkg::LANES-1:0][7:0]           lane_out;
    rlb_pkg::lane_op_t   [rlb_pkg::LANES-1:0] op;
    rlb_pkg::lane_prod_t [rlb_pkg::LANES-1:0] prod;
    logic                                     op_valid;
    logic                                     op_stall;
    logic                                     prod_valid;
    logic                                     prod_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= rlb_pkg::MODE_MULTIPLY;
        end
        else if (cfg_wr_en)
        begin
            mode_reg <= cfg_wr_data;
        end
    end

    assign lane_a = {req_data.base_red, req_data.base_green, req_data.base_blue};
    assign lane_b = {req_data.over_red, req_data.over_green, req_data.over_blue};

    rlb_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .mode     (mode_reg),
        .up_valid (req_valid),
        .up_stall (req_stall),
        .up_a     (lane_a),
        .up_b     (lane_b),
        .dn_valid (op_valid),
        .dn_stall (op_stall),
        .dn_op    (op)
    );

    rlb_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (op_valid),
        .up_stall (op_stall),
        .up_op    (op),
        .dn_valid (prod_valid),
        .dn_stall (prod_stall),
        .dn_prod  (prod)
    );

    rlb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (prod_valid),
        .up_stall (prod_stall),
        .up_prod  (prod),
        .dn_valid (rsp_valid),
        .dn_stall (rsp_stall),
        .dn_val   (lane_out)
    );

    assign rsp_data.out_red   = lane_out[2];
    assign rsp_data.out_green = lane_out[1];
    assign rsp_data.out_blue  = lane_out[0];

`ifndef ASSERT_OFF
    a_mode_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_wr_en |=> $stable(mode_reg))
        else $error("mode changed without a write");

    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !(rsp_valid && rsp_stall) |-> !req_stall)
        else $error("request stalled while result side drains");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (rsp_valid && rsp_stall && op_valid && prod_valid))
        else $error("request stalled with a free stage");
`endif

endmodule

@@ hdl/rlb_prep.sv @@
module rlb_prep (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [1:0]                             mode,
    input  logic                                   up_valid,
    output logic                                   up_stall,
    input  logic [rlb_pkg::LANES-1:0][7:0]         up_a,
    input  logic [rlb_pkg::LANES-1:0][7:0]         up_b,
    output logic                                   dn_valid,
    input  logic                                   dn_stall,
    output rlb_pkg::lane_op_t [rlb_pkg::LANES-1:0] dn_op
);

    logic                                   dn_valid_reg;
    rlb_pkg::lane_op_t [rlb_pkg::LANES-1:0] op_reg;
    rlb_pkg::lane_op_t [rlb_pkg::LANES-1:0] op_next;
    logic                                   load;

    assign load     = !dn_valid_reg || !dn_stall;
    assign up_stall = !load;
    assign dn_valid = dn_valid_reg;
    assign dn_op    = op_reg;

    always_comb
    begin
        for (int i = 0; i < rlb_pkg::LANES; i++)
        begin
            op_next[i].opa         = up_a[i];
            op_next[i].opb         = up_b[i];
            op_next[i].dbl         = 1'b0;
            op_next[i].ctl.inv     = 1'b0;
            op_next[i].ctl.bypass  = 1'b0;
            op_next[i].ctl.byp_val = (up_a[i] > up_b[i]) ? (up_a[i] - up_b[i]) : 8'd0;
            unique case (mode)
                rlb_pkg::MODE_MULTIPLY:
                begin
                end
                rlb_pkg::MODE_SUBTRACT:
                begin
                    op_next[i].ctl.bypass = 1'b1;
                end
                rlb_pkg::MODE_SCREEN:
                begin
                    op_next[i].opa     = ~up_a[i];
                    op_next[i].opb     = ~up_b[i];
                    op_next[i].ctl.inv = 1'b1;
                end
                default:
                begin
                    op_next[i].dbl = 1'b1;
                    if (up_a[i][7])
                    begin
                        op_next[i].opa     = ~up_a[i];
                        op_next[i].opb     = ~up_b[i];
                        op_next[i].ctl.inv = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dn_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            dn_valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && up_valid)
        begin
            op_reg <= op_next;
        end
    end

endmodule

@@ hdl/rlb_mul.sv @@
module rlb_mul (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     up_valid,
    output logic                                     up_stall,
    input  rlb_pkg::lane_op_t   [rlb_pkg::LANES-1:0] up_op,
    output logic                                     dn_valid,
    input  logic                                     dn_stall,
    output rlb_pkg::lane_prod_t [rlb_pkg::LANES-1:0] dn_prod
);

    logic                                     dn_valid_reg;
    rlb_pkg::lane_prod_t [rlb_pkg::LANES-1:0] prod_reg;
    rlb_pkg::lane_prod_t [rlb_pkg::LANES-1:0] prod_next;
    logic                                     load;

    assign load     = !dn_valid_reg || !dn_stall;
    assign up_stall = !load;
    assign dn_valid = dn_valid_reg;
    assign dn_prod  = prod_reg;

    always_comb
    begin
        for (int i = 0; i < rlb_pkg::LANES; i++)
        begin
            logic [16:0] p;
            p = {9'd0, up_op[i].opa} * {9'd0, up_op[i].opb};
            prod_next[i].prod = up_op[i].dbl ? {p[15:0], 1'b0} : p;
            prod_next[i].ctl  = up_op[i].ctl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dn_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            dn_valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && up_valid)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

@@ hdl/rlb_div.sv @@
module rlb_div (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     up_valid,
    output logic                                     up_stall,
    input  rlb_pkg::lane_prod_t [rlb_pkg::LANES-1:0] up_prod,
    output logic                                     dn_valid,
    input  logic                                     dn_stall,
    output logic [rlb_pkg::LANES-1:0][7:0]           dn_val
);

    logic                                    est_valid_reg;
    logic                                    dn_valid_reg;
    rlb_pkg::lane_est_t [rlb_pkg::LANES-1:0] est_reg;
    rlb_pkg::lane_est_t [rlb_pkg::LANES-1:0] est_next;
    logic [rlb_pkg::LANES-1:0][7:0]          val_reg;
    logic [rlb_pkg::LANES-1:0][7:0]          val_next;
    logic [rlb_pkg::LANES-1:0][17:0]         rem;
    logic [rlb_pkg::LANES-1:0][8:0]          quo;
    logic                                    load_out;
    logic                                    load_est;

    assign load_out = !dn_valid_reg || !dn_stall;
    assign load_est = !est_valid_reg || load_out;
    assign up_stall = !load_est;
    assign dn_valid = dn_valid_reg;
    assign dn_val   = val_reg;

    // round(x/255) = floor((2x+255)/510), estimate with 257/2^17
    always_comb
    begin
        for (int i = 0; i < rlb_pkg::LANES; i++)
        begin
            logic [17:0] y;
            logic [26:0] ext;
            logic [26:0] scaled;
            y               = {up_prod[i].prod, 1'b0} + 18'd255;
            ext             = {9'd0, y};
            scaled          = (ext << 8) + ext;
            est_next[i].num = y;
            est_next[i].est = scaled[25:17];
            est_next[i].ctl = up_prod[i].ctl;
        end
    end

    // estimate is exact or one low
    always_comb
    begin
        for (int i = 0; i < rlb_pkg::LANES; i++)
        begin
            logic [17:0] m510;
            m510   = {est_reg[i].est, 9'd0} - {8'd0, est_reg[i].est, 1'b0};
            rem[i] = est_reg[i].num - m510;
            quo[i] = est_reg[i].est + {8'd0, (rem[i] >= 18'd510)};
            if (est_reg[i].ctl.bypass)
            begin
                val_next[i] = est_reg[i].ctl.byp_val;
            end
            else if (est_reg[i].ctl.inv)
            begin
                val_next[i] = 8'd255 - quo[i][7:0];
            end
            else
            begin
                val_next[i] = quo[i][7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_valid_reg <= 1'b0;
            dn_valid_reg  <= 1'b0;
        end
        else
        begin
            if (load_est)
            begin
                est_valid_reg <= up_valid;
            end
            if (load_out)
            begin
                dn_valid_reg <= est_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_est && up_valid)
        begin
            est_reg <= est_next;
        end
        if (load_out && est_valid_reg)
        begin
            val_reg <= val_next;
        end
    end

`ifndef ASSERT_OFF
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        est_valid_reg |-> (rem[0] < 18'd1020 && rem[1] < 18'd1020 && rem[2] < 18'd1020))
        else $error("quotient estimate off by more than one");

    a_quo_fits: assert property (@(posedge clk) disable iff (!rst_n)
        est_valid_reg |-> (quo[0] < 9'd256 && quo[1] < 9'd256 && quo[2] < 9'd256))
        else $error("rounded quotient exceeds channel range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dn_valid_reg && dn_stall |=> dn_valid_reg && $stable(val_reg))
        else $error("stalled result lost");
`endif

endmodule
